@@ rtl/c2meg_pkg.sv @@
// ----------------------------------------------------------------------------
// c2meg_pkg
// Shared types and constants for the controller to MIDI event generator:
// request and response payloads, the job record passed through the queue,
// message kinds and the MIDI status/controller codes.
// ----------------------------------------------------------------------------
package c2meg_pkg;

   // Queue between classifier and message sequencer
   localparam int QUEUE_DEPTH = 2;

   // Number of message kinds one sample can cause
   localparam int MSG_KINDS = 6;

   // Held note register value meaning no note is sounding
   localparam logic [7:0] NO_NOTE = 8'hFF;

   // Status nibbles
   localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
   localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
   localparam logic [3:0] STAT_CC       = 4'hB;
   localparam logic [3:0] STAT_BEND     = 4'hE;

   // Controller numbers
   localparam logic [6:0] CC_MODULATION = 7'd1;
   localparam logic [6:0] CC_BREATH     = 7'd2;
   localparam logic [6:0] CC_BRIGHTNESS = 7'd74;

   // Bend scaling: cents span, 14-bit code center and top
   localparam logic [15:0] BEND_SPAN   = 16'd200;
   localparam logic [14:0] BEND_CENTER = 15'd8192;
   localparam logic [13:0] BEND_TOP    = 14'h3FFF;
   localparam logic [6:0]  BRIGHT_TOP  = 7'd127;
   localparam logic [14:0] BRIGHT_GAIN = 15'd127;

   // Reciprocals of 25 for constant division: ceil(2^k / 25)
   localparam int          BEND_RECIP_SHIFT   = 23;
   localparam logic [18:0] BEND_RECIP         = 19'd335545;
   localparam int          BRIGHT_RECIP_SHIFT = 17;
   localparam logic [12:0] BRIGHT_RECIP       = 13'd5243;

   // Message kinds, numbered in emission order (also the mask bit index)
   typedef enum logic [2:0] {
      MSG_NOTE_OFF   = 3'd0,
      MSG_NOTE_ON    = 3'd1,
      MSG_BREATH     = 3'd2,
      MSG_MODULATION = 3'd3,
      MSG_BEND       = 3'd4,
      MSG_BRIGHTNESS = 3'd5
   } c2meg_msg_type;

   // Input request payload
   typedef struct packed {
      logic [6:0]         note_number;
      logic               gate;
      logic [6:0]         velocity;
      logic signed [15:0] pitch_bend;
      logic [6:0]         modulation;
   } c2meg_req_type;

   // Output response payload
   typedef struct packed {
      logic [7:0] status_byte;
      logic [6:0] first_data;
      logic [6:0] second_data;
      logic       last_in_run;
   } c2meg_rsp_type;

   // One classified sample: which messages to send and their data
   typedef struct packed {
      logic [MSG_KINDS-1:0] mask;
      logic [6:0]           off_note;
      logic [6:0]           on_note;
      logic [6:0]           velocity;
      logic [6:0]           modulation;
      logic [13:0]          bend_code;
      logic [6:0]           brightness;
   } c2meg_job_type;

endpackage

@@ rtl/c2meg_front.sv @@
// ----------------------------------------------------------------------------
// c2meg_front
// Request classifier: encodes bend and brightness, compares against the last
// sent values, tracks the held note and gate, and builds one job per request.
// ----------------------------------------------------------------------------
module c2meg_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  c2meg_pkg::c2meg_req_type req,
   output logic                    push,
   output c2meg_pkg::c2meg_job_type job
);
   import c2meg_pkg::*;

   logic [7:0]  held_note_ff, held_note_in;
   logic        prev_gate_ff;
   logic [6:0]  prev_breath_ff;
   logic [6:0]  prev_mod_ff;
   logic [13:0] prev_code_ff;
   logic [6:0]  prev_bright_ff;

   logic [15:0] bend_u;
   logic        bend_neg;
   logic [15:0] mag16;
   logic        over_span;
   logic [7:0]  mag8;
   logic [17:0] bend_scaled;
   logic [36:0] bend_prod;
   logic [13:0] q_mag;
   logic [14:0] code_sum;
   logic [13:0] code;
   logic [14:0] bright_num;
   logic [24:0] bright_prod;
   logic [6:0]  bright;
   logic        new_note;
   logic        gate_fall;

   // Magnitude of the bend and whether it lies beyond the span
   always_comb begin
      bend_u    = req.pitch_bend;
      bend_neg  = bend_u[15];
      mag16     = bend_neg ? (~bend_u + 16'd1) : bend_u;
      over_span = mag16 > BEND_SPAN;
      mag8      = mag16[7:0];
   end

   // Bend code: |bend| * 1024 / 25 through a reciprocal, then offset and clamp
   always_comb begin
      bend_scaled = {mag8, 10'b0};
      bend_prod   = 37'(bend_scaled) * 37'(BEND_RECIP);
      q_mag       = bend_prod[BEND_RECIP_SHIFT +: 14];
      if (bend_neg) begin
         code_sum = BEND_CENTER - {1'b0, q_mag};
      end else begin
         code_sum = BEND_CENTER + {1'b0, q_mag};
      end
      if (over_span) begin
         code = bend_neg ? 14'd0 : BEND_TOP;
      end else if (code_sum[14]) begin
         code = BEND_TOP;
      end else begin
         code = code_sum[13:0];
      end
   end

   // Brightness: bend * 127 / 200 for positive bend, saturated
   always_comb begin
      bright_num  = 15'(mag8) * BRIGHT_GAIN;
      bright_prod = 25'(bright_num[14:3]) * 25'(BRIGHT_RECIP);
      if (bend_neg) begin
         bright = 7'd0;
      end else if (over_span) begin
         bright = BRIGHT_TOP;
      end else begin
         bright = bright_prod[BRIGHT_RECIP_SHIFT +: 7];
      end
   end

   // Classify note events and build the job
   always_comb begin
      new_note  = req.gate && ({1'b0, req.note_number} != held_note_ff);
      gate_fall = !req.gate && prev_gate_ff;

      held_note_in = held_note_ff;
      if (new_note) begin
         held_note_in = {1'b0, req.note_number};
      end else if (gate_fall) begin
         held_note_in = NO_NOTE;
      end

      job.mask[MSG_NOTE_OFF]   = (new_note || gate_fall) && (held_note_ff != NO_NOTE);
      job.mask[MSG_NOTE_ON]    = new_note;
      job.mask[MSG_BREATH]     = req.velocity != prev_breath_ff;
      job.mask[MSG_MODULATION] = req.modulation != prev_mod_ff;
      job.mask[MSG_BEND]       = code != prev_code_ff;
      job.mask[MSG_BRIGHTNESS] = bright != prev_bright_ff;
      job.off_note             = held_note_ff[6:0];
      job.on_note              = req.note_number;
      job.velocity             = req.velocity;
      job.modulation           = req.modulation;
      job.bend_code            = code;
      job.brightness           = bright;

      push = accept && (job.mask != '0);
   end

   // Advance the last-sent state on every accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         held_note_ff   <= NO_NOTE;
         prev_gate_ff   <= 1'b0;
         prev_breath_ff <= '0;
         prev_mod_ff    <= '0;
         prev_code_ff   <= '0;
         prev_bright_ff <= '0;
      end else if (accept) begin
         held_note_ff   <= held_note_in;
         prev_gate_ff   <= req.gate;
         prev_breath_ff <= req.velocity;
         prev_mod_ff    <= req.modulation;
         prev_code_ff   <= code;
         prev_bright_ff <= bright;
      end
   end

endmodule

@@ rtl/c2meg_queue.sv @@
// ----------------------------------------------------------------------------
// c2meg_queue
// Short job queue between classifier and sequencer, first in first out.
// ----------------------------------------------------------------------------
module c2meg_queue #(
   parameter int DEPTH = c2meg_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  c2meg_pkg::c2meg_job_type push_job,
   input  logic                     pop,
   output c2meg_pkg::c2meg_job_type head_job,
   output logic                     empty,
   output logic                     full
);
   import c2meg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   c2meg_job_type    entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Pointer and fill count update
   always_comb begin
      empty    = count_ff == '0;
      full     = count_ff == FULL_CNT;
      head_job = entries_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/c2meg_back.sv @@
// ----------------------------------------------------------------------------
// c2meg_back
// Message sequencer: sends the messages of one queued job at a time in fixed
// order through a registered response, one per cycle unless rsp_ready stalls.
// ----------------------------------------------------------------------------
module c2meg_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [3:0]               channel,
   input  c2meg_pkg::c2meg_job_type head_job,
   input  logic                     q_empty,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output c2meg_pkg::c2meg_rsp_type rsp_payload
);
   import c2meg_pkg::*;

   c2meg_job_type        work_ff, work_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   c2meg_rsp_type        rsp_ff, rsp_in;
   logic [MSG_KINDS-1:0] sel_bit;
   logic [MSG_KINDS-1:0] rest;
   c2meg_msg_type        kind;
   logic                 advance;
   logic                 emit;
   logic                 last;
   logic                 load;

   // Pick the lowest pending message
   always_comb begin
      kind = MSG_NOTE_OFF;
      for (int i = MSG_KINDS - 1; i >= 0; i--) begin
         if (work_ff.mask[i]) begin
            kind = c2meg_msg_type'(3'(i));
         end
      end
      sel_bit = work_ff.mask & (~work_ff.mask + MSG_KINDS'(1));
      rest    = work_ff.mask & ~sel_bit;
      last    = rest == '0;
   end

   // Encode the selected message
   always_comb begin
      rsp_in.last_in_run = last;
      case (kind)
         MSG_NOTE_OFF: begin
            rsp_in.status_byte = {STAT_NOTE_OFF, channel};
            rsp_in.first_data  = work_ff.off_note;
            rsp_in.second_data = 7'd0;
         end
         MSG_NOTE_ON: begin
            rsp_in.status_byte = {STAT_NOTE_ON, channel};
            rsp_in.first_data  = work_ff.on_note;
            rsp_in.second_data = work_ff.velocity;
         end
         MSG_BREATH: begin
            rsp_in.status_byte = {STAT_CC, channel};
            rsp_in.first_data  = CC_BREATH;
            rsp_in.second_data = work_ff.velocity;
         end
         MSG_MODULATION: begin
            rsp_in.status_byte = {STAT_CC, channel};
            rsp_in.first_data  = CC_MODULATION;
            rsp_in.second_data = work_ff.modulation;
         end
         MSG_BEND: begin
            rsp_in.status_byte = {STAT_BEND, channel};
            rsp_in.first_data  = work_ff.bend_code[6:0];
            rsp_in.second_data = work_ff.bend_code[13:7];
         end
         MSG_BRIGHTNESS: begin
            rsp_in.status_byte = {STAT_CC, channel};
            rsp_in.first_data  = CC_BRIGHTNESS;
            rsp_in.second_data = work_ff.brightness;
         end
         default: begin
            rsp_in.status_byte = {STAT_CC, channel};
            rsp_in.first_data  = 7'd0;
            rsp_in.second_data = 7'd0;
         end
      endcase
   end

   // Drain the working job and refill it from the queue without a bubble
   always_comb begin
      advance = !rsp_valid_ff || rsp_ready;
      emit    = advance && (work_ff.mask != '0);
      load    = (work_ff.mask == '0) || (emit && last);
      pop     = load && !q_empty;

      work_in = work_ff;
      if (emit) begin
         work_in.mask = rest;
      end
      if (pop) begin
         work_in = head_job;
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Advance the working job and the response valid; hold job data
   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff.mask <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         work_ff.mask <= work_in.mask;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff.off_note   <= work_in.off_note;
      work_ff.on_note    <= work_in.on_note;
      work_ff.velocity   <= work_in.velocity;
      work_ff.modulation <= work_in.modulation;
      work_ff.bend_code  <= work_in.bend_code;
      work_ff.brightness <= work_in.brightness;
   end

   // Hold the response payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/controller_to_midi_event_generator.sv @@
// ----------------------------------------------------------------------------
// controller_to_midi_event_generator
// Turns wind controller samples into MIDI channel voice messages.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on req_ carries one controller sample. It is classified in
//   the cycle it is accepted and causes zero to six messages on rsp_, in the
//   order note-off, note-on, CC2 breath, CC1 modulation, pitch bend, CC74
//   brightness; last_in_run marks the final message of a sample. A sample
//   that changes nothing produces no response.
//   The first message of a sample passes through the job queue, the working
//   job register and the response register. The sequencer sends one message
//   per cycle while rsp_ready does not stall it, and samples causing at most
//   one message are then taken every cycle. The job queue holds QUEUE_DEPTH
//   samples between classifier and sequencer; req_ready drops only when full.
//   A stalled rsp_ready holds the current message in its output register and
//   backs up into the queue, then into req_ready.
//   csr_wr_en writes the MIDI channel; write it only while idle.
//   Reset clears the channel to 0, the queue, the held note (none) and all
//   last-sent controller values (zero).
// ----------------------------------------------------------------------------
module controller_to_midi_event_generator #(
   parameter int QUEUE_DEPTH = c2meg_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  c2meg_pkg::c2meg_req_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output c2meg_pkg::c2meg_rsp_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic [3:0]               csr_wr_data
);
   import c2meg_pkg::*;

   logic          channel_ff;
   logic [3:0]    channel_reg_ff;
   logic          accept;
   logic          q_push;
   logic          q_pop;
   logic          q_empty;
   logic          q_full;
   c2meg_job_type push_job;
   c2meg_job_type head_job;

   // Hold the MIDI channel register
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_reg_ff <= '0;
         channel_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            channel_reg_ff <= csr_wr_data;
         end
         channel_ff <= csr_wr_en;
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   c2meg_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .push   (q_push),
      .job    (push_job)
   );

   c2meg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   c2meg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .channel     (channel_reg_ff),
      .head_job    (head_job),
      .q_empty     (q_empty),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Never pop an empty queue
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job queue popped while empty");

   // Never push into a full queue
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job queue pushed while full");

   // Every message carries the configured channel once it has settled
   a_channel_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !channel_ff) |-> (rsp_payload.status_byte[3:0] == channel_reg_ff))
      else $error("response channel differs from channel register");

   // Note-off always carries zero velocity
   a_note_off_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status_byte[7:4] == STAT_NOTE_OFF))
         |-> (rsp_payload.second_data == 7'd0))
      else $error("note-off with nonzero velocity");

endmodule

@@ tb/controller_to_midi_event_generator_tb.sv @@
// ----------------------------------------------------------------------------
// controller_to_midi_event_generator_tb
// Self-checking bench for the wind controller to MIDI message encoder.
// Controller samples are streamed in over req_ with random gaps. An in-bench
// encoder predicts the MIDI messages for each accepted sample. A monitor with
// random back-pressure compares each message on rsp_, field by field, with
// the oldest prediction. The MIDI channel is changed between phases, only
// while the block is idle.
// ----------------------------------------------------------------------------
module controller_to_midi_event_generator_tb;
   import c2meg_pkg::*;

   localparam int RANDOM_PHASES    = 5;
   localparam int SAMPLES_PER_PHASE = 92;
   localparam int SETTLE_CYCLES    = 20;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   c2meg_req_type req_payload = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   c2meg_rsp_type rsp_payload;
   logic          csr_wr_en = 1'b0;
   logic [3:0]    csr_wr_data = 4'd0;

   // Samples waiting to be sent, and messages still due from the block
   c2meg_req_type pending_samples[$];
   c2meg_rsp_type expected_msgs[$];

   // Encoder state kept by the bench
   logic [3:0]  midi_chan;
   logic [7:0]  held_note;
   logic        prior_gate;
   logic [6:0]  last_breath;
   logic [6:0]  prior_mod;
   logic [13:0] last_bend_code;
   logic [6:0]  last_bright;

   int            fail_count = 0;
   int            gap_left;
   int            stall_left;
   bit            steady_flow = 1'b0;
   c2meg_rsp_type due_msg;
   c2meg_req_type last_loaded = '0;

   controller_to_midi_event_generator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      #10000000;
      $display("Verification failed");
      $finish;
   end

   // Append one predicted message on the current channel
   function automatic void queue_msg(input logic [3:0] stat, input logic [6:0] d1,
                                     input logic [6:0] d2);
      c2meg_rsp_type m;
      m.status_byte = {stat, midi_chan};
      m.first_data  = d1;
      m.second_data = d2;
      m.last_in_run = 1'b0;
      expected_msgs.push_back(m);
   endfunction

   // Predict the messages one accepted sample causes and advance the state
   function automatic void encode_sample(input c2meg_req_type s);
      int          cents;
      int          q;
      int          br;
      int          first_idx;
      logic [13:0] code;
      logic [6:0]  bright;
      first_idx = expected_msgs.size();
      cents = int'(s.pitch_bend);

      // 14-bit bend code around center, clamped both ways
      q = cents * 8192 / 200;
      if (q > 8192) q = 8192;
      if (q < -8192) q = -8192;
      q = q + 8192;
      if (q > 16383) q = 16383;
      code = q[13:0];

      // Brightness follows positive bend only
      br = cents * 127 / 200;
      if (br < 0) br = 0;
      if (br > 127) br = 127;
      bright = br[6:0];

      // Note messages
      if (s.gate && {1'b0, s.note_number} != held_note) begin
         if (held_note != NO_NOTE) queue_msg(STAT_NOTE_OFF, held_note[6:0], 7'd0);
         queue_msg(STAT_NOTE_ON, s.note_number, s.velocity);
         held_note = {1'b0, s.note_number};
      end else if (!s.gate && prior_gate) begin
         if (held_note != NO_NOTE) queue_msg(STAT_NOTE_OFF, held_note[6:0], 7'd0);
         held_note = NO_NOTE;
      end
      prior_gate = s.gate;

      // Controllers, each only on change
      if (s.velocity != last_breath) begin
         queue_msg(STAT_CC, CC_BREATH, s.velocity);
         last_breath = s.velocity;
      end
      if (s.modulation != prior_mod) begin
         queue_msg(STAT_CC, CC_MODULATION, s.modulation);
         prior_mod = s.modulation;
      end
      if (code != last_bend_code) begin
         queue_msg(STAT_BEND, code[6:0], code[13:7]);
         last_bend_code = code;
      end
      if (bright != last_bright) begin
         queue_msg(STAT_CC, CC_BRIGHTNESS, bright);
         last_bright = bright;
      end

      // Flag the final message of this sample
      if (expected_msgs.size() > first_idx)
         expected_msgs[expected_msgs.size() - 1].last_in_run = 1'b1;
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void add_sample(input int note, input bit gate, input int vel,
                                      input int cents, input int modv);
      c2meg_req_type s;
      s.note_number = note[6:0];
      s.gate        = gate;
      s.velocity    = vel[6:0];
      s.pitch_bend  = cents[15:0];
      s.modulation  = modv[6:0];
      pending_samples.push_back(s);
      last_loaded = s;
   endfunction

   // Next random sample: mostly playing-like steps from the last one, some noise
   function automatic c2meg_req_type random_sample(input c2meg_req_type prior);
      c2meg_req_type s;
      int            cents;
      s = prior;
      if ($urandom_range(0, 99) < 15) begin
         s.note_number = 7'($urandom_range(0, 127));
         s.gate        = 1'($urandom_range(0, 1));
         s.velocity    = 7'($urandom_range(0, 127));
         s.pitch_bend  = 16'($urandom_range(0, 65535));
         s.modulation  = 7'($urandom_range(0, 127));
      end else begin
         if ($urandom_range(0, 4) == 0) s.gate = ~prior.gate;
         if ($urandom_range(0, 2) == 0) s.note_number = 7'($urandom_range(0, 127));
         if ($urandom_range(0, 1) == 0) s.velocity = 7'($urandom_range(0, 127));
         if ($urandom_range(0, 2) == 0) s.modulation = 7'($urandom_range(0, 127));
         case ($urandom_range(0, 4))
            0: begin
               cents = int'($urandom_range(0, 500)) - 250;
               s.pitch_bend = cents[15:0];
            end
            1: begin
               cents = int'($urandom_range(0, 420)) - 210;
               s.pitch_bend = cents[15:0];
            end
            2: begin
               s.pitch_bend = 16'($urandom_range(0, 65535));
            end
            default: begin
               s.pitch_bend = prior.pitch_bend;
            end
         endcase
      end
      return s;
   endfunction

   // Wait until nothing is queued, in flight or due, then let the block settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_msgs.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_channel(input logic [3:0] chan);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= chan;
      midi_chan = chan;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Request driver: load the next sample once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && req_ready) encode_sample(req_payload);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left  <= gap_left - 1;
            end else if (pending_samples.size() > 0) begin
               req_payload <= pending_samples.pop_front();
               req_valid   <= 1'b1;
               gap_left    <= pick_idle();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted message, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_msgs.size() == 0) begin
               $error("unexpected message: status_byte %h first_data %0d second_data %0d",
                      rsp_payload.status_byte, rsp_payload.first_data,
                      rsp_payload.second_data);
               fail_count++;
            end else begin
               due_msg = expected_msgs.pop_front();
               if (rsp_payload.status_byte !== due_msg.status_byte) begin
                  $error("status_byte: expected %h, actual %h",
                         due_msg.status_byte, rsp_payload.status_byte);
                  fail_count++;
               end
               if (rsp_payload.first_data !== due_msg.first_data) begin
                  $error("first_data: expected %0d, actual %0d",
                         due_msg.first_data, rsp_payload.first_data);
                  fail_count++;
               end
               if (rsp_payload.second_data !== due_msg.second_data) begin
                  $error("second_data: expected %0d, actual %0d",
                         due_msg.second_data, rsp_payload.second_data);
                  fail_count++;
               end
               if (rsp_payload.last_in_run !== due_msg.last_in_run) begin
                  $error("last_in_run: expected %0d, actual %0d",
                         due_msg.last_in_run, rsp_payload.last_in_run);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left <= pick_idle();
         end
      end
   end

   // Main sequence
   initial begin
      midi_chan      = 4'd0;
      held_note      = NO_NOTE;
      prior_gate     = 1'b0;
      last_breath    = 7'd0;
      prior_mod      = 7'd0;
      last_bend_code = 14'd0;
      last_bright    = 7'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: note changes, gate edges, bend and field extremes
      add_sample(60, 1, 100, 0, 0);
      add_sample(60, 1, 100, 0, 0);
      add_sample(62, 1, 100, 0, 0);
      add_sample(62, 0, 100, 0, 0);
      add_sample(62, 0, 100, 0, 0);
      add_sample(5, 0, 0, 0, 127);
      add_sample(5, 0, 0, 32767, 127);
      add_sample(5, 0, 0, -32768, 0);
      add_sample(5, 0, 0, 200, 0);
      add_sample(5, 0, 0, 199, 0);
      add_sample(5, 0, 0, -200, 0);
      add_sample(5, 0, 0, -199, 0);
      add_sample(5, 0, 0, -1, 0);
      add_sample(5, 0, 0, 1, 0);
      add_sample(5, 0, 0, 2, 0);
      add_sample(5, 0, 0, 0, 0);
      add_sample(0, 1, 127, 0, 0);
      add_sample(127, 1, 0, 0, 127);
      add_sample(127, 1, 0, 0, 127);
      add_sample(3, 1, 90, 150, 64);
      add_sample(3, 0, 90, 150, 64);
      add_sample(3, 1, 90, 150, 64);
      add_sample(3, 0, 0, -32768, 0);
      wait_idle();

      // Random phases, each after a channel write; the sender holds off between them
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       set_channel(4'd15);
            1:       set_channel(4'd0);
            3:       set_channel(4'd15);
            default: set_channel(4'($urandom_range(1, 14)));
         endcase
         steady_flow = (p == 2);
         for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
            last_loaded = random_sample(last_loaded);
            pending_samples.push_back(last_loaded);
         end
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
